### hw/rtl/hhsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_pkg - shared types and helpers for the http header stream parser
// Event kinds, queue entry layout, character classes and version arithmetic.
// ----------------------------------------------------------------------------
package hhsp_pkg;

	// accumulator width for the version numbers, saturating at all ones
	localparam int VERSION_WIDTH = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int PTR_W         = $clog2(QUEUE_DEPTH);

	// characters the parser looks for
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_T       = 8'h54;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_DEL     = 8'h7f;
	localparam logic [7:0] CH_CTL_MAX = 8'h1f;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5a;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// event kinds on the output channel
	typedef enum logic [3:0] {
		KIND_METHOD_BYTE = 4'd0,
		KIND_METHOD_END  = 4'd1,
		KIND_URI_BYTE    = 4'd2,
		KIND_URI_END     = 4'd3,
		KIND_VERSION     = 4'd4,
		KIND_STATUS      = 4'd5,
		KIND_REASON_BYTE = 4'd6,
		KIND_REASON_END  = 4'd7,
		KIND_NAME_BYTE   = 4'd8,
		KIND_VALUE_BYTE  = 4'd9,
		KIND_HDR_END     = 4'd10,
		KIND_OK          = 4'd11,
		KIND_FAIL        = 4'd12
	} kind_t;

	// one queue entry: the events caused by one item, one or two of them
	typedef struct packed {
		logic        two;
		kind_t       k0;
		logic [7:0]  d0;
		logic [15:0] maj;
		logic [15:0] min;
		logic [9:0]  st;
		kind_t       k1;
		logic [7:0]  d1;
	} entry_t;

	function automatic logic is_ctl(input logic [7:0] c);
		is_ctl = (c <= CH_CTL_MAX) || (c == CH_DEL);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		case (c) inside
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: is_sep = 1'b1;
			default: is_sep = 1'b0;
		endcase
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		is_token = !c[7] && !is_ctl(c) && !is_sep(c);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == CH_SP) || (c == CH_TAB);
	endfunction

	// header names fold A-Z only
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c | CASE_BIT) : c;
	endfunction

	// acc * 10 + digit, saturating; shifts and adds stand in for the multiply
	function automatic logic [VERSION_WIDTH-1:0] ver_step(
		input logic [VERSION_WIDTH-1:0] acc,
		input logic [3:0]               dig
	);
		logic [VERSION_WIDTH+3:0] wide;
		logic [VERSION_WIDTH+3:0] lim;
		wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (VERSION_WIDTH+4)'(dig);
		lim  = {4'd0, {VERSION_WIDTH{1'b1}}};
		ver_step = (wide > lim) ? {VERSION_WIDTH{1'b1}} : wide[VERSION_WIDTH-1:0];
	endfunction

endpackage

### hw/rtl/hhsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_queue - short event queue between parser front and emitter back
// Holds per-item event groups so that each side may stall on its own.
// ----------------------------------------------------------------------------
module hhsp_queue
	import hhsp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head_entry,
	output logic   head_valid
);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/hhsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_front - byte classifier and parse state machine
// Takes one byte per item, advances the parse state and queues its events.
// ----------------------------------------------------------------------------
module hhsp_front
	import hhsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] byte_in,
	input  logic       restart,
	input  logic       parse_mode,
	output logic       push,
	output entry_t     push_entry
);

	typedef enum logic [26:0] {
		S_METHOD_START = 27'd1 << 0,
		S_METHOD       = 27'd1 << 1,
		S_URI_START    = 27'd1 << 2,
		S_URI          = 27'd1 << 3,
		S_VER_H        = 27'd1 << 4,
		S_VER_T1       = 27'd1 << 5,
		S_VER_T2       = 27'd1 << 6,
		S_VER_P        = 27'd1 << 7,
		S_VER_SLASH    = 27'd1 << 8,
		S_MAJ_START    = 27'd1 << 9,
		S_MAJ          = 27'd1 << 10,
		S_MIN_START    = 27'd1 << 11,
		S_MIN_REQ      = 27'd1 << 12,
		S_MIN_RESP     = 27'd1 << 13,
		S_ST1          = 27'd1 << 14,
		S_ST2          = 27'd1 << 15,
		S_ST3          = 27'd1 << 16,
		S_ST_SP        = 27'd1 << 17,
		S_REASON       = 27'd1 << 18,
		S_START_LF     = 27'd1 << 19,
		S_HDR_START    = 27'd1 << 20,
		S_NAME         = 27'd1 << 21,
		S_FIRST_LWS    = 27'd1 << 22,
		S_VALUE        = 27'd1 << 23,
		S_LWS_IN       = 27'd1 << 24,
		S_HDR_LF       = 27'd1 << 25,
		S_HEADERS_LF   = 27'd1 << 26
	} state_t;

	state_t                   state_q;
	logic                     mode_q;
	logic [VERSION_WIDTH-1:0] maj_q;
	logic [VERSION_WIDTH-1:0] min_q;
	logic [9:0]               st_q;
	logic                     pend_q;
	logic                     sent_q;
	logic                     seen_q;
	logic                     done_q;

	state_t                   cur_state, nxt_state;
	logic                     cur_mode;
	logic [VERSION_WIDTH-1:0] cur_maj, nxt_maj;
	logic [VERSION_WIDTH-1:0] cur_min, nxt_min;
	logic [9:0]               cur_st, nxt_st;
	logic                     cur_pend, nxt_pend;
	logic                     cur_sent, nxt_sent;
	logic                     cur_seen, nxt_seen;
	logic                     cur_done, nxt_done;
	logic                     has_ev;
	entry_t                   ent;
	kind_t                    main_k;
	logic [7:0]               main_d;
	logic                     main_fail;
	logic [3:0]               dig;

	assign dig = byte_in[3:0];

	// view of the state after an optional restart
	always_comb begin
		if (restart) begin
			cur_mode  = parse_mode;
			cur_state = parse_mode ? S_VER_H : S_METHOD_START;
			cur_maj   = '0;
			cur_min   = '0;
			cur_st    = '0;
			cur_pend  = 1'b0;
			cur_sent  = 1'b0;
			cur_seen  = 1'b0;
			cur_done  = 1'b0;
		end else begin
			cur_mode  = mode_q;
			cur_state = state_q;
			cur_maj   = maj_q;
			cur_min   = min_q;
			cur_st    = st_q;
			cur_pend  = pend_q;
			cur_sent  = sent_q;
			cur_seen  = seen_q;
			cur_done  = done_q;
		end
	end

	// parse step: next state and the events this byte causes
	always_comb begin
		nxt_state = cur_state;
		nxt_maj   = cur_maj;
		nxt_min   = cur_min;
		nxt_st    = cur_st;
		nxt_pend  = cur_pend;
		nxt_sent  = cur_sent;
		nxt_seen  = cur_seen;
		nxt_done  = cur_done;
		has_ev    = 1'b0;
		ent       = '0;
		main_k    = KIND_REASON_BYTE;
		main_d    = '0;
		main_fail = 1'b0;

		if (!cur_done) begin
			unique case (cur_state)
				S_METHOD_START: begin
					if (is_token(byte_in)) begin
						has_ev = 1'b1; ent.k0 = KIND_METHOD_BYTE; ent.d0 = byte_in;
						nxt_state = S_METHOD;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_METHOD: begin
					if (byte_in == CH_SP) begin
						has_ev = 1'b1; ent.k0 = KIND_METHOD_END;
						nxt_state = S_URI_START;
					end else if (is_token(byte_in)) begin
						has_ev = 1'b1; ent.k0 = KIND_METHOD_BYTE; ent.d0 = byte_in;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_URI_START: begin
					has_ev = 1'b1;
					if (!is_ctl(byte_in)) begin
						ent.k0 = KIND_URI_BYTE; ent.d0 = byte_in;
						nxt_state = S_URI;
					end else begin
						ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_URI: begin
					has_ev = 1'b1;
					if (byte_in == CH_SP) begin
						ent.k0 = KIND_URI_END;
						nxt_state = S_VER_H;
					end else if (is_ctl(byte_in)) begin
						ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end else begin
						ent.k0 = KIND_URI_BYTE; ent.d0 = byte_in;
					end
				end
				S_VER_H, S_VER_T1, S_VER_T2, S_VER_P, S_VER_SLASH: begin
					if ((cur_state == S_VER_H     && byte_in == CH_H) ||
					    (cur_state == S_VER_T1    && byte_in == CH_T) ||
					    (cur_state == S_VER_T2    && byte_in == CH_T) ||
					    (cur_state == S_VER_P     && byte_in == CH_P) ||
					    (cur_state == S_VER_SLASH && byte_in == CH_SLASH)) begin
						nxt_state = state_t'({cur_state[25:0], 1'b0});
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_MAJ_START: begin
					if (is_digit(byte_in)) begin
						nxt_maj   = VERSION_WIDTH'(dig);
						nxt_state = S_MAJ;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_MAJ: begin
					if (byte_in == CH_DOT) begin
						nxt_state = S_MIN_START;
					end else if (is_digit(byte_in)) begin
						nxt_maj = ver_step(cur_maj, dig);
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_MIN_START: begin
					if (is_digit(byte_in)) begin
						nxt_min   = VERSION_WIDTH'(dig);
						nxt_state = cur_mode ? S_MIN_RESP : S_MIN_REQ;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_MIN_REQ, S_MIN_RESP: begin
					if ((cur_state == S_MIN_REQ  && byte_in == CH_CR) ||
					    (cur_state == S_MIN_RESP && byte_in == CH_SP)) begin
						has_ev  = 1'b1;
						ent.k0  = KIND_VERSION;
						ent.maj = 16'(cur_maj);
						ent.min = 16'(cur_min);
						nxt_maj = '0;
						nxt_min = '0;
						nxt_state = (cur_state == S_MIN_REQ) ? S_START_LF : S_ST1;
					end else if (is_digit(byte_in)) begin
						nxt_min = ver_step(cur_min, dig);
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_ST1, S_ST2, S_ST3: begin
					if (is_digit(byte_in)) begin
						// at most two digits held before the third, so this stays below 1000
						nxt_st    = 10'((cur_st << 3) + (cur_st << 1) + 10'(dig));
						nxt_state = state_t'({cur_state[25:0], 1'b0});
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_ST_SP: begin
					if (byte_in == CH_SP) begin
						nxt_state = S_REASON;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_REASON: begin
					// main event of the byte, preceded by the status once per message
					if (byte_in == CH_CR) begin
						main_k = KIND_REASON_END;
						nxt_state = S_START_LF;
					end else if (is_ws(byte_in) || !is_ctl(byte_in)) begin
						main_k = KIND_REASON_BYTE; main_d = byte_in;
					end else begin
						main_k = KIND_FAIL; main_d = byte_in; main_fail = 1'b1;
					end
					has_ev = 1'b1;
					if (!cur_sent) begin
						ent.k0   = KIND_STATUS;
						ent.st   = cur_st;
						ent.two  = 1'b1;
						ent.k1   = main_k;
						ent.d1   = main_d;
						nxt_sent = 1'b1;
						nxt_st   = '0;
					end else begin
						ent.k0 = main_k;
						ent.d0 = main_d;
					end
					if (main_fail) begin
						nxt_done = 1'b1;
					end
				end
				S_START_LF, S_HDR_LF: begin
					if (byte_in == CH_LF) begin
						nxt_state = S_HDR_START;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_HDR_START: begin
					if (byte_in == CH_CR) begin
						has_ev   = cur_pend;
						ent.k0   = KIND_HDR_END;
						nxt_pend = 1'b0;
						nxt_state = S_HEADERS_LF;
					end else if (cur_pend && is_ws(byte_in)) begin
						nxt_state = S_LWS_IN;
					end else if (is_token(byte_in)) begin
						has_ev = 1'b1;
						if (cur_pend) begin
							ent.k0  = KIND_HDR_END;
							ent.two = 1'b1;
							ent.k1  = KIND_NAME_BYTE;
							ent.d1  = to_lower(byte_in);
						end else begin
							ent.k0 = KIND_NAME_BYTE;
							ent.d0 = to_lower(byte_in);
						end
						nxt_pend  = 1'b1;
						nxt_seen  = 1'b0;
						nxt_state = S_NAME;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_NAME: begin
					if (byte_in == CH_COLON) begin
						nxt_state = S_FIRST_LWS;
					end else if (is_token(byte_in)) begin
						has_ev = 1'b1; ent.k0 = KIND_NAME_BYTE; ent.d0 = to_lower(byte_in);
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_FIRST_LWS, S_VALUE: begin
					// leading blanks are skipped before the first value byte
					if (byte_in == CH_CR) begin
						nxt_state = S_HDR_LF;
					end else if (is_ws(byte_in)) begin
						if (cur_state == S_VALUE) begin
							nxt_state = S_LWS_IN;
						end
					end else if (is_ctl(byte_in)) begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_VALUE_BYTE; ent.d0 = byte_in;
						nxt_seen  = 1'b1;
						nxt_state = S_VALUE;
					end
				end
				S_LWS_IN: begin
					// a run of blanks or a fold collapses to one space
					if (byte_in == CH_CR) begin
						nxt_state = S_HDR_LF;
					end else if (is_ws(byte_in)) begin
						nxt_state = S_LWS_IN;
					end else if (!is_ctl(byte_in)) begin
						has_ev = 1'b1;
						if (cur_seen) begin
							ent.k0  = KIND_VALUE_BYTE;
							ent.d0  = CH_SP;
							ent.two = 1'b1;
							ent.k1  = KIND_VALUE_BYTE;
							ent.d1  = byte_in;
						end else begin
							ent.k0 = KIND_VALUE_BYTE;
							ent.d0 = byte_in;
						end
						nxt_seen  = 1'b1;
						nxt_state = S_VALUE;
					end else begin
						has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
						nxt_done = 1'b1;
					end
				end
				S_HEADERS_LF: begin
					has_ev   = 1'b1;
					nxt_done = 1'b1;
					if (byte_in == CH_LF) begin
						ent.k0 = KIND_OK;
					end else begin
						ent.k0 = KIND_FAIL; ent.d0 = byte_in;
					end
				end
				default: begin
					has_ev = 1'b1; ent.k0 = KIND_FAIL; ent.d0 = byte_in;
					nxt_done = 1'b1;
				end
			endcase
		end
	end

	assign push       = accept && has_ev;
	assign push_entry = ent;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_METHOD_START;
			mode_q  <= 1'b0;
			maj_q   <= '0;
			min_q   <= '0;
			st_q    <= '0;
			pend_q  <= 1'b0;
			sent_q  <= 1'b0;
			seen_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (accept) begin
			state_q <= nxt_state;
			mode_q  <= cur_mode;
			maj_q   <= nxt_maj;
			min_q   <= nxt_min;
			st_q    <= nxt_st;
			pend_q  <= nxt_pend;
			sent_q  <= nxt_sent;
			seen_q  <= nxt_seen;
			done_q  <= nxt_done;
		end
	end

endmodule

### hw/rtl/hhsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_back - event emitter
// Unpacks queued event groups into single output items with a result register.
// ----------------------------------------------------------------------------
module hhsp_back
	import hhsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head_entry,
	input  logic        head_valid,
	output logic        pop,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [3:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] major_version,
	output logic [15:0] minor_version,
	output logic [9:0]  status_code,
	output logic        last_of_run
);

	logic        valid_q;
	logic        sel_q;
	logic [3:0]  kind_q;
	logic [7:0]  data_q;
	logic [15:0] maj_q;
	logic [15:0] min_q;
	logic [9:0]  st_q;
	logic        last_q;
	logic        load;
	logic        is_last;

	// output register is free when empty or being taken
	assign load    = head_valid && (!valid_q || !event_stall);
	assign is_last = !head_entry.two || sel_q;
	assign pop     = load && is_last;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !is_last;
			end else if (!event_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload, numbers ride only on the first event of a group
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= sel_q ? head_entry.k1 : head_entry.k0;
			data_q <= sel_q ? head_entry.d1 : head_entry.d0;
			maj_q  <= sel_q ? 16'd0 : head_entry.maj;
			min_q  <= sel_q ? 16'd0 : head_entry.min;
			st_q   <= sel_q ? 10'd0 : head_entry.st;
			last_q <= is_last;
		end
	end

	assign event_valid   = valid_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign major_version = maj_q;
	assign minor_version = min_q;
	assign status_code   = st_q;
	assign last_of_run   = last_q;

endmodule

### hw/rtl/http_header_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_stream_parser - HTTP/1.1 start line and header parser
// Byte-per-item parser streaming tagged events for method, URI, version,
// status, reason, header names and values, and the message outcome.
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  byte    | byte_valid / byte_stall      | byte_in, restart
//  event   | event_valid / event_stall    | kind, data_byte, major_version,
//          |                              | minor_version, status_code,
//          |                              | last_of_run
//  config  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One byte is parsed per cycle by the front state machine while byte_stall
// is low; its one or two events enter a four-entry queue and leave through
// the output register at one event per cycle while event_stall is low, so
// the two events of a byte are offered one after the other. A byte's first
// event passes through the queue and then the output register.
// Reset clears all parser state to the request start with no clearing pass.
// byte_stall rises only while the event queue is full.
// ----------------------------------------------------------------------------
module http_header_stream_parser
	import hhsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_in,
	input  logic        restart,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [3:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] major_version,
	output logic [15:0] minor_version,
	output logic [9:0]  status_code,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic   parse_mode_q;
	logic   accept;
	logic   push;
	entry_t push_entry;
	logic   full;
	logic   pop;
	entry_t head_entry;
	logic   head_valid;

	// configuration register, word 0 only
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, parse_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			parse_mode_q <= pwdata[0];
		end
	end

	// input handshake
	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	hhsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_in    (byte_in),
		.restart    (restart),
		.parse_mode (parse_mode_q),
		.push       (push),
		.push_entry (push_entry)
	);

	hhsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_entry (head_entry),
		.head_valid (head_valid)
	);

	hhsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_entry    (head_entry),
		.head_valid    (head_valid),
		.pop           (pop),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.major_version (major_version),
		.minor_version (minor_version),
		.status_code   (status_code),
		.last_of_run   (last_of_run)
	);

endmodule

### hw/rtl/hhsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_checker - port-level checks for the http header stream parser
// Output handshake rules and event shape, bound onto the top level.
// ----------------------------------------------------------------------------
module hhsp_checker
	import hhsp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        event_valid,
	input logic        event_stall,
	input logic [3:0]  kind,
	input logic [7:0]  data_byte,
	input logic [9:0]  status_code,
	input logic        last_of_run
);

	// a stalled item stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid)
		else $error("event_valid dropped while stalled");

	// a stalled item keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> $stable(kind) && $stable(data_byte))
		else $error("event payload changed while stalled");

	// ok and fail close the run of the byte that caused them
	a_outcome_last: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (kind == KIND_OK || kind == KIND_FAIL) |-> last_of_run)
		else $error("outcome event not last of its run");

	// status is followed by the reason event of the same byte
	a_status_first: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && kind == KIND_STATUS |-> !last_of_run)
		else $error("status event without a following event");

	// status code travels only with the status event
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && kind != KIND_STATUS |-> status_code == 10'd0)
		else $error("status code on a non-status event");

endmodule

bind http_header_stream_parser hhsp_checker u_hhsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.event_valid (event_valid),
	.event_stall (event_stall),
	.kind        (kind),
	.data_byte   (data_byte),
	.status_code (status_code),
	.last_of_run (last_of_run)
);

### dv/http_header_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_stream_parser_tb - self-checking bench for the header parser
// Feeds request and response heads byte by byte, starting with a short
// directed script and then running randomised messages with folds, odd
// whitespace, saturating versions, corruption, truncation and noise. A
// behavioural parser in the bench predicts the event stream, which is
// compared field by field with what leaves the block. Both channels idle
// and stall at random; the parse mode is changed between rounds.
// ----------------------------------------------------------------------------
module http_header_stream_parser_tb
	import hhsp_pkg::*;
();

	localparam int          CLK_PERIOD    = 10;
	localparam int          RESET_CYCLES  = 12;
	localparam int          RANDOM_ITEMS  = 1400;
	localparam int          SETTLE_CYCLES = 8;
	localparam logic [2:0]  ADDR_PARSE_MODE = 3'd0;
	localparam logic [39:0] PROTO_TAG     = {CH_H, CH_T, CH_T, CH_P, CH_SLASH};

	// parser position within the message head
	typedef enum int {
		ST_METHOD_START, ST_METHOD, ST_URI_START, ST_URI,
		ST_VER_H, ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH,
		ST_MAJ_START, ST_MAJ, ST_MIN_START, ST_MIN_REQ, ST_MIN_RESP,
		ST_CODE1, ST_CODE2, ST_CODE3, ST_CODE_SP, ST_REASON, ST_START_LF,
		ST_HDR_START, ST_NAME, ST_FIRST_LWS, ST_VALUE, ST_LWS_IN,
		ST_HDR_LF, ST_HEADERS_LF
	} hdr_state_t;

	typedef enum logic [1:0] {PARSING, HEAD_OK, HEAD_FAILED} verdict_t;

	typedef struct {
		kind_t       k;
		logic [7:0]  d;
		logic [15:0] maj;
		logic [15:0] mnr;
		logic [9:0]  st;
		logic        last;
	} parse_event_t;

	typedef struct {
		logic       rs;
		logic [7:0] b;
		bit         typed;
		kind_t      k;
		logic [7:0] d;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  byte_in;
	logic        restart;
	logic        event_valid;
	logic        event_stall;
	logic [3:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] major_version;
	logic [15:0] minor_version;
	logic [9:0]  status_code;
	logic        last_of_run;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and the configuration copy
	hdr_state_t  state_now;
	verdict_t    verdict;
	int unsigned maj_acc;
	int unsigned min_acc;
	int unsigned code_acc;
	bit          name_open;
	bit          code_done;
	bit          value_started;
	bit          resp_latched;
	logic        mode_reg;

	parse_event_t step_events[$];
	parse_event_t expected_events[$];
	parse_event_t want;
	logic [8:0]   msg_bytes[$];
	int           mismatch_count = 0;
	int           burst_left = 1;

	// directed script: request head with empty value, fold, ok, then a bad restart
	script_row_t script [0:25] = '{
		'{1'b1, "G",      1'b1, KIND_METHOD_BYTE, "G"},
		'{1'b0, CH_SP,    1'b1, KIND_METHOD_END,  8'h00},
		'{1'b0, 8'hff,    1'b1, KIND_URI_BYTE,    8'hff},
		'{1'b0, CH_SP,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_H,     1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_T,     1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_T,     1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_P,     1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_SLASH, 1'b0, KIND_FAIL,        8'h00},
		'{1'b0, "1",      1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_DOT,   1'b0, KIND_FAIL,        8'h00},
		'{1'b0, "1",      1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_CR,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_LF,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, "Z",      1'b1, KIND_NAME_BYTE,   "z"},
		'{1'b0, CH_COLON, 1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_CR,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_LF,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_TAB,   1'b0, KIND_FAIL,        8'h00},
		'{1'b0, "v",      1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_CR,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_LF,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_CR,    1'b0, KIND_FAIL,        8'h00},
		'{1'b0, CH_LF,    1'b1, KIND_OK,          8'h00},
		'{1'b0, "~",      1'b0, KIND_FAIL,        8'h00},
		'{1'b1, 8'h00,    1'b1, KIND_FAIL,        8'h00}
	};

	http_header_stream_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_in       (byte_in),
		.restart       (restart),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.major_version (major_version),
		.minor_version (minor_version),
		.status_code   (status_code),
		.last_of_run   (last_of_run),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// character classes
	function automatic bit ctl_char(input logic [7:0] c);
		return (c < 8'd32) || (c == 8'd127);
	endfunction

	function automatic bit sep_char(input logic [7:0] c);
		string seps = "()<>@,;:\\\"/[]?={} \t";
		for (int i = 0; i < seps.len(); i++)
			if (seps[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit token_char(input logic [7:0] c);
		return (c < 8'd128) && !ctl_char(c) && !sep_char(c);
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int unsigned ver_next(input int unsigned acc, input logic [7:0] c);
		int unsigned v;
		v = acc * 10 + (c - CH_ZERO);
		return (v > (1 << VERSION_WIDTH) - 1) ? (1 << VERSION_WIDTH) - 1 : v;
	endfunction

	// predictor
	function automatic void add_event(input kind_t k, input logic [7:0] d,
			input logic [15:0] mj = 16'd0, input logic [15:0] mn = 16'd0,
			input logic [9:0] sc = 10'd0);
		if (step_events.size() < 2)
			step_events.push_back('{k, d, mj, mn, sc, 1'b0});
	endfunction

	function automatic void reject(input logic [7:0] b);
		add_event(KIND_FAIL, b);
		verdict = HEAD_FAILED;
	endfunction

	function automatic void restart_parser();
		resp_latched  = mode_reg;
		state_now     = mode_reg ? ST_VER_H : ST_METHOD_START;
		maj_acc       = 0;
		min_acc       = 0;
		code_acc      = 0;
		name_open     = 1'b0;
		code_done     = 1'b0;
		value_started = 1'b0;
		verdict       = PARSING;
	endfunction

	function automatic void value_char(input logic [7:0] b);
		if (b == CH_CR) begin
			state_now = ST_HDR_LF;
		end else if (blank_char(b)) begin
			state_now = ST_LWS_IN;
		end else if (ctl_char(b)) begin
			reject(b);
		end else begin
			add_event(KIND_VALUE_BYTE, b);
			value_started = 1'b1;
			state_now = ST_VALUE;
		end
	endfunction

	function automatic void minor_char(input logic [7:0] b, input logic [7:0] term,
			input hdr_state_t nxt);
		if (b == term) begin
			add_event(KIND_VERSION, 8'h00, 16'(maj_acc), 16'(min_acc));
			maj_acc = 0;
			min_acc = 0;
			state_now = nxt;
		end else if (digit_char(b)) begin
			min_acc = ver_next(min_acc, b);
		end else begin
			reject(b);
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic rs);
		step_events.delete();
		if (rs)
			restart_parser();
		if (verdict != PARSING)
			return;
		case (state_now)
			ST_METHOD_START: begin
				if (token_char(b)) begin
					add_event(KIND_METHOD_BYTE, b);
					state_now = ST_METHOD;
				end else reject(b);
			end
			ST_METHOD: begin
				if (b == CH_SP) begin
					add_event(KIND_METHOD_END, 8'h00);
					state_now = ST_URI_START;
				end else if (token_char(b)) add_event(KIND_METHOD_BYTE, b);
				else reject(b);
			end
			ST_URI_START: begin
				if (!ctl_char(b)) begin
					add_event(KIND_URI_BYTE, b);
					state_now = ST_URI;
				end else reject(b);
			end
			ST_URI: begin
				if (b == CH_SP) begin
					add_event(KIND_URI_END, 8'h00);
					state_now = ST_VER_H;
				end else if (ctl_char(b)) reject(b);
				else add_event(KIND_URI_BYTE, b);
			end
			ST_VER_H, ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH: begin
				if (b == PROTO_TAG[39 - 8 * (state_now - ST_VER_H) -: 8])
					state_now = hdr_state_t'(state_now + 1);
				else reject(b);
			end
			ST_MAJ_START: begin
				if (digit_char(b)) begin
					maj_acc = b - CH_ZERO;
					state_now = ST_MAJ;
				end else reject(b);
			end
			ST_MAJ: begin
				if (b == CH_DOT) state_now = ST_MIN_START;
				else if (digit_char(b)) maj_acc = ver_next(maj_acc, b);
				else reject(b);
			end
			ST_MIN_START: begin
				if (digit_char(b)) begin
					min_acc = b - CH_ZERO;
					state_now = resp_latched ? ST_MIN_RESP : ST_MIN_REQ;
				end else reject(b);
			end
			ST_MIN_REQ:  minor_char(b, CH_CR, ST_START_LF);
			ST_MIN_RESP: minor_char(b, CH_SP, ST_CODE1);
			ST_CODE1, ST_CODE2, ST_CODE3: begin
				if (digit_char(b)) begin
					code_acc = (code_acc * 10 + (b - CH_ZERO)) % 1000;
					state_now = hdr_state_t'(state_now + 1);
				end else reject(b);
			end
			ST_CODE_SP: begin
				if (b == CH_SP) state_now = ST_REASON;
				else reject(b);
			end
			ST_REASON: begin
				// status goes out once, alongside the first reason byte
				if (!code_done) begin
					add_event(KIND_STATUS, 8'h00, 16'd0, 16'd0, 10'(code_acc));
					code_done = 1'b1;
					code_acc = 0;
				end
				if (b == CH_CR) begin
					add_event(KIND_REASON_END, 8'h00);
					state_now = ST_START_LF;
				end else if (blank_char(b) || !ctl_char(b)) begin
					add_event(KIND_REASON_BYTE, b);
				end else reject(b);
			end
			ST_START_LF, ST_HDR_LF: begin
				if (b == CH_LF) state_now = ST_HDR_START;
				else reject(b);
			end
			ST_HDR_START: begin
				if (b == CH_CR) begin
					if (name_open)
						add_event(KIND_HDR_END, 8'h00);
					name_open = 1'b0;
					state_now = ST_HEADERS_LF;
				end else if (name_open && blank_char(b)) begin
					state_now = ST_LWS_IN;
				end else if (token_char(b)) begin
					if (name_open)
						add_event(KIND_HDR_END, 8'h00);
					add_event(KIND_NAME_BYTE, fold_case(b));
					name_open = 1'b1;
					value_started = 1'b0;
					state_now = ST_NAME;
				end else reject(b);
			end
			ST_NAME: begin
				if (b == CH_COLON) state_now = ST_FIRST_LWS;
				else if (token_char(b)) add_event(KIND_NAME_BYTE, fold_case(b));
				else reject(b);
			end
			ST_FIRST_LWS: begin
				if (!blank_char(b))
					value_char(b);
			end
			ST_VALUE: value_char(b);
			ST_LWS_IN: begin
				// a run of blanks or a fold collapses to one space between words
				if (b == CH_CR) begin
					state_now = ST_HDR_LF;
				end else if (blank_char(b)) begin
				end else if (!ctl_char(b)) begin
					if (value_started)
						add_event(KIND_VALUE_BYTE, CH_SP);
					add_event(KIND_VALUE_BYTE, b);
					value_started = 1'b1;
					state_now = ST_VALUE;
				end else reject(b);
			end
			ST_HEADERS_LF: begin
				if (b == CH_LF) begin
					add_event(KIND_OK, 8'h00);
					verdict = HEAD_OK;
				end else reject(b);
			end
			default: reject(b);
		endcase
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
	endfunction

	// message generation
	function automatic void put(input logic [7:0] b);
		msg_bytes.push_back({1'b0, b});
	endfunction

	function automatic logic [7:0] any_token();
		logic [7:0] c;
		do c = 8'($urandom_range(33, 126)); while (!token_char(c));
		return c;
	endfunction

	function automatic logic [7:0] any_blank();
		return $urandom_range(0, 1) ? CH_SP : CH_TAB;
	endfunction

	function automatic logic [7:0] any_text(input bit allow_blank);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 8'($urandom_range(128, 255));
		if (r == 2 && allow_blank)
			return any_blank();
		return 8'($urandom_range(33, 126));
	endfunction

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'("A" + $urandom_range(0, 25));
		if (r == 1)
			return 8'("a" + $urandom_range(0, 25));
		return any_token();
	endfunction

	// mostly one digit, sometimes long enough to saturate
	function automatic void put_number();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 7) : 1;
		repeat (n) put(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void put_header();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) put(name_char());
		put(CH_COLON);
		n = $urandom_range(0, 2);
		repeat (n) put(any_blank());
		n = $urandom_range(0, 3);
		for (int w = 0; w < n; w++) begin
			if (w > 0) begin
				if ($urandom_range(0, 3) == 0) begin
					put(CH_CR);
					put(CH_LF);
				end
				repeat ($urandom_range(1, 2)) put(any_blank());
			end
			repeat ($urandom_range(1, 5)) put(any_text(1'b0));
		end
		n = $urandom_range(0, 2);
		repeat (n) put(any_blank());
		put(CH_CR);
		put(CH_LF);
	endfunction

	function automatic void build_message(input logic resp);
		int n;
		msg_bytes.delete();
		if (!resp) begin
			n = $urandom_range(1, 6);
			repeat (n) put(any_token());
			put(CH_SP);
			n = $urandom_range(1, 8);
			repeat (n) put(any_text(1'b0));
			put(CH_SP);
		end
		put(CH_H);
		put(CH_T);
		put(CH_T);
		put(CH_P);
		put(CH_SLASH);
		put_number();
		put(CH_DOT);
		put_number();
		if (resp) begin
			put(CH_SP);
			repeat (3) put(8'(CH_ZERO + $urandom_range(0, 9)));
			put(CH_SP);
			n = $urandom_range(0, 8);
			repeat (n) put(any_text(1'b1));
		end
		put(CH_CR);
		put(CH_LF);
		// a folded line with no header before it
		if ($urandom_range(0, 15) == 0)
			put(any_blank());
		n = $urandom_range(0, 4);
		repeat (n) put_header();
		put(CH_CR);
		put(CH_LF);
		// corrupt one byte or cut the message short now and then
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(0, msg_bytes.size() - 1);
			msg_bytes[n] = {1'b0, 8'($urandom_range(0, 255))};
		end
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > n)
				void'(msg_bytes.pop_back());
		end
		msg_bytes[0][8] = 1'b1;
	endfunction

	function automatic void build_noise();
		int n;
		msg_bytes.delete();
		n = $urandom_range(1, 12);
		repeat (n) put(8'($urandom_range(0, 255)));
		msg_bytes[0][8] = 1'b1;
	endfunction

	// byte channel: one item, then a random gap at the end of a burst
	task automatic push_byte(input logic [7:0] b, input logic rs, input bit typed,
			input kind_t tk, input logic [7:0] td);
		int gap;
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_in    <= b;
		restart    <= rs;
		do @(posedge clk); while (byte_stall !== 1'b0);
		parse_byte(b, rs);
		if (typed)
			expected_events.push_back('{tk, td, 16'd0, 16'd0, 10'd0, 1'b1});
		else
			foreach (step_events[i])
				expected_events.push_back(step_events[i]);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// wait until every expected event is out and the block has gone quiet
	task automatic settle_down();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_PARSE_MODE;
		pwdata  <= {31'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		mode_reg = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// event channel stall pattern: clear, coin flip, rare, or mostly stalled
	initial begin
		int style;
		int span;
		event_stall = 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			span  = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (style == 0)
					event_stall <= 1'b0;
				else if (style == 1)
					event_stall <= 1'($urandom_range(0, 1));
				else if (style == 2)
					event_stall <= ($urandom_range(0, 7) == 0);
				else
					event_stall <= ($urandom_range(0, 15) < 11);
			end
		end
	end

	// compare each accepted event with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && event_valid === 1'b1 && event_stall == 1'b0) begin
			if (expected_events.size() == 0) begin
				mismatch_count++;
				$display("%0t: expected no event, got kind %0d data %02h",
					$time, kind, data_byte);
			end else begin
				want = expected_events.pop_front();
				if (kind !== want.k || data_byte !== want.d || major_version !== want.maj
						|| minor_version !== want.mnr || status_code !== want.st
						|| last_of_run !== want.last) begin
					mismatch_count++;
					$display({"%0t: expected kind %0d data %02h ver %0d.%0d status %0d",
						" last %0b, got kind %0d data %02h ver %0d.%0d status %0d",
						" last %0b"},
						$time, want.k, want.d, want.maj, want.mnr, want.st, want.last,
						kind, data_byte, major_version, minor_version, status_code,
						last_of_run);
				end
			end
		end
	end

	// stimulus
	initial begin
		int sent;
		int budget;
		int round_no;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_in    = 8'h00;
		restart    = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = ADDR_PARSE_MODE;
		pwdata     = 32'd0;
		mode_reg   = 1'b0;
		restart_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed script in request mode straight after reset
		foreach (script[i])
			push_byte(script[i].b, script[i].rs, script[i].typed, script[i].k, script[i].d);

		// random rounds, each under its own parse mode
		sent = 0;
		round_no = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_down();
			if (round_no == 0)
				write_mode(1'b1);
			else if (round_no == 1)
				write_mode(1'b0);
			else
				write_mode(1'($urandom_range(0, 1)));
			budget = sent + $urandom_range(150, 300);
			while (sent < budget && sent < RANDOM_ITEMS) begin
				if ($urandom_range(0, 7) == 0)
					build_noise();
				else
					build_message(mode_reg);
				sent += msg_bytes.size();
				// trailing bytes, usually ignored once the head is done
				if ($urandom_range(0, 3) == 0)
					put(8'($urandom_range(0, 255)));
				foreach (msg_bytes[j])
					push_byte(msg_bytes[j][7:0], msg_bytes[j][8], 1'b0, KIND_FAIL, 8'h00);
			end
			round_no++;
		end
		settle_down();

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/hhsp_pkg.sv
hw/rtl/hhsp_queue.sv
hw/rtl/hhsp_front.sv
hw/rtl/hhsp_back.sv
hw/rtl/http_header_stream_parser.sv
hw/rtl/hhsp_checker.sv
dv/http_header_stream_parser_tb.sv
